[hdl/sync_word_bit_deframer_defines.svh]
// assertion macros for the sync word bit deframer
`ifndef SYNC_WORD_BIT_DEFRAMER_DEFINES_SVH
`define SYNC_WORD_BIT_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/swd_pkg.sv]
// types and constants shared by the sync word bit deframer
package swd_pkg;

  localparam logic [31:0] SYNC_WORD       = 32'hCCCC_A64C;
  localparam logic [31:0] SYNC_WORD_INV   = 32'h3333_59B3;
  localparam logic [7:0]  FRAME_BYTES_RST = 8'd176;

  localparam logic EV_SYNC = 1'b0;
  localparam logic EV_BYTE = 1'b1;

  typedef struct packed {
    logic [31:0] history;
    logic        hunting;
    logic [2:0]  bit_phase;
    logic [7:0]  bytes_taken;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       event_kind;
    logic       sync_inverted;
    logic [7:0] frame_byte;
    logic [7:0] byte_position;
    logic       frame_last;
  } result_t;

endpackage

[hdl/swd_step.sv]
// one-byte step: eight bit shifts, sync search and frame byte extraction
module swd_step
  import swd_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] in_byte,
  input  logic [7:0] frame_bytes,
  output state_t     st_next,
  output result_t    res
);

  logic [39:0] w;
  logic [7:0]  hit;
  logic [7:0]  hit_inv;
  logic        sync_found;
  logic [2:0]  sync_pos;
  logic        sync_inv;
  logic [7:0]  cnt_next;
  logic        last;

  // candidate histories after each bit, first match wins
  always_comb begin
    w = {st.history, in_byte};
    hit = '0;
    hit_inv = '0;
    for (int k = 0; k < 8; k++) begin
      hit[k]     = (w[(7 - k) +: 32] == SYNC_WORD) || (w[(7 - k) +: 32] == SYNC_WORD_INV);
      hit_inv[k] = (w[(7 - k) +: 32] == SYNC_WORD_INV);
    end
    sync_pos = '0;
    sync_inv = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      if (hit[k]) begin
        sync_pos = 3'(k);
        sync_inv = hit_inv[k];
      end
    end
    sync_found = |hit;
  end

  assign cnt_next = st.bytes_taken + 8'd1;
  assign last     = (cnt_next == frame_bytes);

  always_comb begin
    st_next = st;
    st_next.history = w[31:0];
    res = '0;
    if (st.hunting) begin
      if (sync_found) begin
        st_next.hunting     = 1'b0;
        st_next.bit_phase   = ~sync_pos;
        st_next.bytes_taken = '0;
        res.valid           = 1'b1;
        res.event_kind      = EV_SYNC;
        res.sync_inverted   = sync_inv;
      end
    end else begin
      st_next.bytes_taken = cnt_next;
      res.valid           = 1'b1;
      res.event_kind      = EV_BYTE;
      res.frame_byte      = w[st.bit_phase +: 8];
      res.byte_position   = st.bytes_taken;
      res.frame_last      = last;
      if (last) begin
        // rest of the input byte is dropped
        st_next.history   = w[st.bit_phase +: 32];
        st_next.hunting   = 1'b1;
        st_next.bit_phase = '0;
      end
    end
  end

endmodule

[hdl/sync_word_bit_deframer.sv]
// top level of the sync word bit deframer
// an accepted byte is held in the input register, and its result is then registered at the outputs
// throughput: one byte per cycle while the output is not stalled, all eight bit steps resolved in one pass
// the rate is set by the state update from the input register
// reset clears the pipeline valids, resets the search state to hunting and sets frame_bytes to 176
`include "sync_word_bit_deframer_defines.svh"

module sync_word_bit_deframer
  import swd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       event_kind,
  output logic       sync_inverted,
  output logic [7:0] frame_byte,
  output logic [7:0] byte_position,
  output logic       frame_last
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic [7:0] frame_bytes;
  state_t     state;
  state_t     state_next;
  result_t    res;
  logic       adv;

  assign adv      = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || adv;

  swd_step u_step (
    .st          (state),
    .in_byte     (hold_byte),
    .frame_bytes (frame_bytes),
    .st_next     (state_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid          <= 1'b0;
      out_valid           <= 1'b0;
      frame_bytes         <= FRAME_BYTES_RST;
      state.history       <= '0;
      state.hunting       <= 1'b1;
      state.bit_phase     <= '0;
      state.bytes_taken   <= '0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (adv) begin
        state     <= state_next;
        out_valid <= res.valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        frame_bytes <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
    if (adv && res.valid) begin
      event_kind    <= res.event_kind;
      sync_inverted <= res.sync_inverted;
      frame_byte    <= res.frame_byte;
      byte_position <= res.byte_position;
      frame_last    <= res.frame_last;
    end
  end

  `SWD_ASSERT_NOW(a_sync_fields_zero, out_valid && (event_kind == EV_SYNC), (frame_byte == 8'd0) && (byte_position == 8'd0) && !frame_last, "sync request carries frame fields")
  `SWD_ASSERT_NEXT(a_sync_ends_hunt, adv && res.valid && (res.event_kind == EV_SYNC), !state.hunting && (state.bytes_taken == 8'd0), "sync did not end the hunt")
  `SWD_ASSERT_NEXT(a_last_restarts_hunt, adv && res.valid && res.frame_last, state.hunting && (state.bit_phase == 3'd0), "frame end did not restart the hunt")

endmodule
